>>> hdl/fgcvt_pkg.sv
// shared types and constants for the flash junk-sector victim table
// field widths, operation and zone-kind codes, controller/datapath bundles
// no dependencies
`default_nettype none

package fgcvt_pkg;

  // default sizing handed to the top level parameters
  localparam int NUM_ZONES_DEF  = 1024;
  localparam int COUNT_BITS_DEF = 16;

  // fixed payload widths
  localparam int MODE_W     = 3;
  localparam int ZONE_W     = 10;
  localparam int AMOUNT_W   = 16;
  localparam int VALUE_W    = 16;
  localparam int ACTIVE_W   = 11;
  localparam int MAXJ_W     = 16;
  localparam int PROD_W     = MAXJ_W + AMOUNT_W;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  // register map
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_ZONES = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_MAX_JUNK     = CFG_IDX_W'(1);
  localparam logic [ACTIVE_W-1:0]  ACTIVE_RST       = ACTIVE_W'(1024);
  localparam logic [MAXJ_W-1:0]    MAXJ_RST         = MAXJ_W'(32768);

  // zones above this many junk sectors are counted as heavy
  localparam logic [8:0] HEAVY_LIMIT = 9'(128 * 3);
  // percentage base of the force-recycle threshold
  localparam int PCT_BASE = 100;

  typedef enum logic [MODE_W-1:0] {
    MODE_ADD     = 3'd0,
    MODE_SET_CUR = 3'd1,
    MODE_SEARCH  = 3'd2,
    MODE_DELETE  = 3'd3,
    MODE_DROP    = 3'd4,
    MODE_COUNT   = 3'd5,
    MODE_FORCE   = 3'd6,
    MODE_READ    = 3'd7
  } mode_t;

  typedef enum logic [1:0] {
    KIND_NORMAL  = 2'd0,
    KIND_CURRENT = 2'd1,
    KIND_DROPPED = 2'd2
  } kind_t;

  // one datapath operation per cycle
  typedef enum logic [3:0] {
    OP_NOP,
    OP_CLEAR,
    OP_LOAD,
    OP_RD_ZONE,
    OP_ADD_WR,
    OP_KIND_OLD,
    OP_KIND_NEW,
    OP_ZAP,
    OP_SCAN_INIT,
    OP_SCAN,
    OP_FIN,
    OP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    mode_t mode;
    logic  ok;
    logic  same_cur;
    logic  cur_valid;
    logic  lim_zero;
    logic  scan_last;
    logic  clear_last;
    logic  out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

>>> hdl/fgcvt_if.sv
// valid/ready channel interfaces for the victim table: item, result, register write
// depends on fgcvt_pkg for field widths
`default_nettype none

interface fgcvt_in_if import fgcvt_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [MODE_W-1:0]   mode;
  logic [ZONE_W-1:0]   zone;
  logic [AMOUNT_W-1:0] amount;

  modport source (output valid, mode, zone, amount, input ready);
  modport sink   (input valid, mode, zone, amount, output ready);
endinterface

interface fgcvt_out_if import fgcvt_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               found;
  logic [ZONE_W-1:0]  zone_out;
  logic [VALUE_W-1:0] value;
  logic               status;

  modport source (output valid, found, zone_out, value, status, input ready);
  modport sink   (input valid, found, zone_out, value, status, output ready);
endinterface

interface fgcvt_cfg_if import fgcvt_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> hdl/flash_gc_victim_table_unit.sv
// top level of the flash junk-sector victim table
// depends on fgcvt_pkg, fgcvt_if, fgcvt_ctrl, fgcvt_dp (and fgcvt_ram below it)
//
//   channel   dir   beat contents                         handshake
//   in_ch     in    mode, zone, amount                    valid/ready
//   out_ch    out   found, zone_out, value, status        valid/ready
//   cfg_ch    in    index, data (0 active_zones, 1 max)   valid/ready, ready always high
//
// one item in flight; updates pass decode, an optional add or set-new step, finish and
// emit; scan modes (search, count, force) add scan and tail steps if a zone is active,
// one zone read a cycle from the zone store's single read port
// after reset a clearing pass writes every zone entry, with in_ready low
// the result sits in an output register: a stalled out_ch only holds the next item at
// its final step, in_ready rises at the edge that loads the result
`default_nettype none

module flash_gc_victim_table_unit import fgcvt_pkg::*; #(
  parameter int NUM_ZONES  = NUM_ZONES_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  fgcvt_in_if.sink    in_ch,
  fgcvt_out_if.source out_ch,
  fgcvt_cfg_if.sink   cfg_ch
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  fgcvt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  fgcvt_dp #(
    .NUM_ZONES  (NUM_ZONES),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .stat         (stat),
    .in_mode      (in_ch.mode),
    .in_zone      (in_ch.zone),
    .in_amount    (in_ch.amount),
    .cfg_valid    (cfg_ch.valid),
    .cfg_ready    (cfg_ch.ready),
    .cfg_index    (cfg_ch.index),
    .cfg_data     (cfg_ch.data),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .out_found    (out_ch.found),
    .out_zone_out (out_ch.zone_out),
    .out_value    (out_ch.value),
    .out_status   (out_ch.status)
  );

  // a scan is never started over an empty zone range
  a_scan_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_SCAN) |-> !stat.lim_zero)
    else $error("zone scan issued with zero active zones");

  // only one item in flight
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("item taken while another is in flight");

  // a rejected zone never carries search or count data
  a_status_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.status) |-> (!out_ch.found && out_ch.value == '0))
    else $error("out-of-range result carries data");

  // a finished result lands in the output register
  a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_EMIT && stat.out_free) |=> out_ch.valid)
    else $error("result not loaded into output register");

endmodule

`default_nettype wire

>>> hdl/fgcvt_ram.sv
// generic single-write, single-read RAM with registered read data
// no dependencies
`default_nettype none

module fgcvt_ram #(
  parameter int  WIDTH = 8,
  parameter int  DEPTH = 16,
  localparam int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, data held between reads
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

>>> hdl/fgcvt_dp.sv
// datapath of the victim table: zone store, registers, scan accumulators, result
// depends on fgcvt_pkg and fgcvt_ram
`default_nettype none

module fgcvt_dp import fgcvt_pkg::*; #(
  parameter int NUM_ZONES  = NUM_ZONES_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire dp_cmd_t               cmd,
  output dp_stat_t                   stat,
  // item payload
  input  wire logic [MODE_W-1:0]     in_mode,
  input  wire logic [ZONE_W-1:0]     in_zone,
  input  wire logic [AMOUNT_W-1:0]   in_amount,
  // register writes
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  // result
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic                       out_found,
  output logic [ZONE_W-1:0]          out_zone_out,
  output logic [VALUE_W-1:0]         out_value,
  output logic                       out_status
);

  localparam int AW    = $clog2(NUM_ZONES);
  localparam int NZ_W  = $clog2(NUM_ZONES + 1);
  localparam int LIM_W = (NZ_W > ACTIVE_W) ? NZ_W : ACTIVE_W;
  localparam int BW    = (COUNT_BITS > AMOUNT_W) ? COUNT_BITS : AMOUNT_W;
  localparam int CNT_W = NZ_W;
  localparam int FW    = (BW + 8 > PROD_W) ? BW + 8 : PROD_W;

  // item and register state
  mode_t                 mode_r;
  logic [ZONE_W-1:0]     zone_r;
  logic [AMOUNT_W-1:0]   amount_r;
  logic [ACTIVE_W-1:0]   active_r;
  logic [MAXJ_W-1:0]     maxj_r;
  logic [ZONE_W-1:0]     cur_r;
  logic                  cur_valid_r;

  // scan state
  logic [AW-1:0]         idx_r;
  logic [AW-1:0]         idx_d_r;
  logic                  scan_vld_r;
  logic [BW-1:0]         best_r;
  logic                  hit_r;
  logic [AW-1:0]         id_r;
  logic [CNT_W-1:0]      n_r;
  logic [PROD_W-1:0]     prod_r;

  // finished result and output stage
  logic                  res_found_r,  res_found_nxt;
  logic [ZONE_W-1:0]     res_zone_r,   res_zone_nxt;
  logic [VALUE_W-1:0]    res_value_r,  res_value_nxt;
  logic                  res_status_r, res_status_nxt;
  logic                  out_vld_r;
  logic                  out_found_r;
  logic [ZONE_W-1:0]     out_zone_r;
  logic [VALUE_W-1:0]    out_value_r;
  logic                  out_status_r;

  // store ports
  logic                  j_we, k_we, rd_en;
  logic [AW-1:0]         wr_addr, rd_addr;
  logic [COUNT_BITS-1:0] j_wd, j_rd;
  logic [1:0]            k_wd, k_rd;

  logic [LIM_W-1:0]      active_ext, lim;
  logic [AW-1:0]         zone_addr, cur_addr;
  logic                  ok, out_free;
  logic [BW:0]           sum;
  logic [COUNT_BITS-1:0] sat;
  logic [BW-1:0]         junk_ext;
  logic                  is_normal;
  logic                  thr_hit;

  // zone limit and range check
  assign active_ext = LIM_W'(active_r);
  assign lim        = (active_ext < LIM_W'(NUM_ZONES)) ? active_ext : LIM_W'(NUM_ZONES);
  assign ok         = LIM_W'(zone_r) < lim;
  assign zone_addr  = AW'(zone_r);
  assign cur_addr   = AW'(cur_r);
  assign out_free   = !out_vld_r || out_ready;

  // status toward the controller
  always_comb begin
    stat.mode       = mode_r;
    stat.ok         = ok;
    stat.same_cur   = cur_valid_r && (cur_r == zone_r);
    stat.cur_valid  = cur_valid_r;
    stat.lim_zero   = (lim == '0);
    stat.scan_last  = (LIM_W'(idx_r) == lim - LIM_W'(1));
    stat.clear_last = (idx_r == AW'(NUM_ZONES - 1));
    stat.out_free   = out_free;
  end

  // saturating add of the item amount
  assign sum = (BW+1)'(j_rd) + (BW+1)'(amount_r);
  assign sat = (|sum[BW:COUNT_BITS]) ? '1 : sum[COUNT_BITS-1:0];

  // store address and data selection
  always_comb begin
    j_we    = 1'b0;
    k_we    = 1'b0;
    rd_en   = 1'b0;
    wr_addr = zone_addr;
    rd_addr = zone_addr;
    j_wd    = '0;
    k_wd    = 2'(KIND_NORMAL);
    unique case (cmd.op)
      OP_CLEAR: begin
        j_we    = 1'b1;
        k_we    = 1'b1;
        wr_addr = idx_r;
      end
      OP_RD_ZONE: begin
        rd_en = 1'b1;
      end
      OP_ADD_WR: begin
        j_we = 1'b1;
        j_wd = sat;
      end
      OP_KIND_OLD: begin
        k_we    = 1'b1;
        wr_addr = cur_addr;
      end
      OP_KIND_NEW: begin
        k_we = 1'b1;
        k_wd = 2'(KIND_CURRENT);
      end
      OP_ZAP: begin
        j_we = 1'b1;
        k_we = 1'b1;
        k_wd = (mode_r == MODE_DROP) ? 2'(KIND_DROPPED) : 2'(KIND_NORMAL);
      end
      OP_SCAN: begin
        rd_en   = 1'b1;
        rd_addr = idx_r;
      end
      default: begin
      end
    endcase
  end

  fgcvt_ram #(.WIDTH(COUNT_BITS), .DEPTH(NUM_ZONES)) u_junk_ram (
    .clk     (clk),
    .wr_en   (j_we),
    .wr_addr (wr_addr),
    .wr_data (j_wd),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (j_rd)
  );

  fgcvt_ram #(.WIDTH(2), .DEPTH(NUM_ZONES)) u_kind_ram (
    .clk     (clk),
    .wr_en   (k_we),
    .wr_addr (wr_addr),
    .wr_data (k_wd),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (k_rd)
  );

  // configuration registers, always writable
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= ACTIVE_RST;
      maxj_r   <= MAXJ_RST;
    end else if (cfg_valid) begin
      if (cfg_index == REG_ACTIVE_ZONES) begin
        active_r <= cfg_data[ACTIVE_W-1:0];
      end else if (cfg_index == REG_MAX_JUNK) begin
        maxj_r <= cfg_data[MAXJ_W-1:0];
      end
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD) begin
      mode_r   <= mode_t'(in_mode);
      zone_r   <= in_zone;
      amount_r <= in_amount;
    end
  end

  // current zone tracking
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r       <= '0;
      cur_valid_r <= 1'b0;
    end else if (cmd.op == OP_KIND_NEW) begin
      cur_r       <= zone_r;
      cur_valid_r <= 1'b1;
    end
  end

  // sweep address for clearing and scans, with tracking of the registered read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r      <= '0;
      scan_vld_r <= 1'b0;
    end else begin
      scan_vld_r <= (cmd.op == OP_SCAN);
      if (cmd.op == OP_SCAN_INIT) begin
        idx_r <= '0;
      end else if (cmd.op == OP_CLEAR || cmd.op == OP_SCAN) begin
        idx_r <= idx_r + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_d_r <= idx_r;
  end

  // scan accumulators: running best, its zone, heavy zone count
  assign junk_ext  = BW'(j_rd);
  assign is_normal = (k_rd == 2'(KIND_NORMAL));

  always_ff @(posedge clk) begin
    if (cmd.op == OP_SCAN_INIT) begin
      best_r <= (mode_r == MODE_FORCE) ? '0 : BW'(amount_r);
      hit_r  <= 1'b0;
      id_r   <= '0;
      n_r    <= '0;
      prod_r <= PROD_W'(maxj_r) * PROD_W'(amount_r);
    end else if (scan_vld_r) begin
      if (is_normal && (best_r <= junk_ext)) begin
        best_r <= junk_ext;
        id_r   <= idx_d_r;
        hit_r  <= 1'b1;
      end
      if (junk_ext > BW'(HEAVY_LIMIT)) begin
        n_r <= n_r + CNT_W'(1);
      end
    end
  end

  // force flag: floor(prod / 100) <= best  <=>  prod < 100 * (best + 1)
  assign thr_hit = FW'(prod_r) < (FW'(best_r) + FW'(1)) * FW'(PCT_BASE);

  // result selection by mode
  always_comb begin
    res_found_nxt  = 1'b0;
    res_zone_nxt   = '0;
    res_value_nxt  = '0;
    res_status_nxt = 1'b0;
    unique case (mode_r)
      MODE_SEARCH: begin
        if (hit_r) begin
          res_found_nxt = 1'b1;
          res_zone_nxt  = ZONE_W'(id_r);
          res_value_nxt = VALUE_W'(best_r);
        end
      end
      MODE_COUNT: begin
        res_value_nxt = VALUE_W'(n_r);
      end
      MODE_FORCE: begin
        res_found_nxt = thr_hit;
      end
      MODE_READ: begin
        res_status_nxt = !ok;
        if (ok) begin
          res_value_nxt = VALUE_W'(j_rd);
        end
      end
      MODE_ADD, MODE_SET_CUR, MODE_DELETE, MODE_DROP: begin
        res_status_nxt = !ok;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_FIN) begin
      res_found_r  <= res_found_nxt;
      res_zone_r   <= res_zone_nxt;
      res_value_r  <= res_value_nxt;
      res_status_r <= res_status_nxt;
    end
  end

  // output register, decoupled from the item side
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (cmd.op == OP_EMIT && out_free) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_EMIT && out_free) begin
      out_found_r  <= res_found_r;
      out_zone_r   <= res_zone_r;
      out_value_r  <= res_value_r;
      out_status_r <= res_status_r;
    end
  end

  assign out_valid    = out_vld_r;
  assign out_found    = out_found_r;
  assign out_zone_out = out_zone_r;
  assign out_value    = out_value_r;
  assign out_status   = out_status_r;

endmodule

`default_nettype wire

>>> hdl/fgcvt_ctrl.sv
// controller of the victim table: sequences clearing, updates and zone scans
// depends on fgcvt_pkg
`default_nettype none

module fgcvt_ctrl import fgcvt_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire dp_stat_t stat,
  output dp_cmd_t       cmd
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DEC,
    S_ADDWR,
    S_SETNEW,
    S_SCAN,
    S_TAIL,
    S_FIN,
    S_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   in_rdy_r, in_rdy_nxt;

  // next state and datapath operation
  always_comb begin
    state_nxt  = state_r;
    in_rdy_nxt = in_rdy_r;
    cmd.op     = OP_NOP;
    unique case (state_r)
      S_CLEAR: begin
        cmd.op = OP_CLEAR;
        if (stat.clear_last) begin
          state_nxt  = S_IDLE;
          in_rdy_nxt = 1'b1;
        end
      end
      S_IDLE: begin
        if (in_valid && in_rdy_r) begin
          cmd.op     = OP_LOAD;
          state_nxt  = S_DEC;
          in_rdy_nxt = 1'b0;
        end
      end
      S_DEC: begin
        unique case (stat.mode)
          MODE_ADD: begin
            if (stat.ok) begin
              cmd.op    = OP_RD_ZONE;
              state_nxt = S_ADDWR;
            end else begin
              state_nxt = S_FIN;
            end
          end
          MODE_READ: begin
            if (stat.ok) begin
              cmd.op = OP_RD_ZONE;
            end
            state_nxt = S_FIN;
          end
          MODE_SET_CUR: begin
            if (!stat.ok || stat.same_cur) begin
              state_nxt = S_FIN;
            end else begin
              if (stat.cur_valid) begin
                cmd.op = OP_KIND_OLD;
              end
              state_nxt = S_SETNEW;
            end
          end
          MODE_DELETE, MODE_DROP: begin
            if (stat.ok) begin
              cmd.op = OP_ZAP;
            end
            state_nxt = S_FIN;
          end
          MODE_SEARCH, MODE_COUNT, MODE_FORCE: begin
            cmd.op    = OP_SCAN_INIT;
            state_nxt = stat.lim_zero ? S_FIN : S_SCAN;
          end
        endcase
      end
      S_ADDWR: begin
        cmd.op    = OP_ADD_WR;
        state_nxt = S_FIN;
      end
      S_SETNEW: begin
        cmd.op    = OP_KIND_NEW;
        state_nxt = S_FIN;
      end
      S_SCAN: begin
        cmd.op = OP_SCAN;
        if (stat.scan_last) begin
          state_nxt = S_TAIL;
        end
      end
      // last read data is folded in this cycle
      S_TAIL: begin
        state_nxt = S_FIN;
      end
      S_FIN: begin
        cmd.op    = OP_FIN;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        cmd.op = OP_EMIT;
        if (stat.out_free) begin
          state_nxt  = S_IDLE;
          in_rdy_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt  = S_IDLE;
        in_rdy_nxt = 1'b1;
      end
    endcase
  end

  // state and registered ready
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLEAR;
      in_rdy_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      in_rdy_r <= in_rdy_nxt;
    end
  end

  assign in_ready = in_rdy_r;

endmodule

`default_nettype wire
